// ----- rtl/prrs_pkg.sv -----
// Shared types and codes for the process-table round-robin scheduler.
// Self-contained; used by prrs_seq and the top level.
`timescale 1ns / 1ps
`default_nettype none

package prrs_pkg;

  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned CHAN_IN_W  = 16;
  localparam int unsigned EXIT_W     = 32;
  localparam int unsigned STATE_W    = 3;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned RPID_W     = 16;

  // Stream payload widths: channel + exit value in, the full result out.
  localparam int unsigned IN_DATA_W  = CHAN_IN_W + EXIT_W;
  localparam int unsigned OUT_DATA_W = STATUS_W + 1 + SLOT_OUT_W + RPID_W + EXIT_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_YIELD  = 3'd0,
    ACT_SLEEP  = 3'd1,
    ACT_WAKEUP = 3'd2,
    ACT_EXIT   = 3'd3,
    ACT_WAIT   = 3'd4,
    ACT_FORK   = 3'd5,
    ACT_CREATE = 3'd6
  } action_e;

  typedef enum logic [STATE_W-1:0] {
    ST_UNUSED   = 3'd0,
    ST_SLEEPING = 3'd1,
    ST_READY    = 3'd2,
    ST_RUNNING  = 3'd3,
    ST_ZOMBIE   = 3'd4
  } slot_state_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_NO_CUR   = 3'd1,
    STS_FULL     = 3'd2,
    STS_NO_CHILD = 3'd3,
    STS_BLOCKED  = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [EXIT_W-1:0] exit_value;
    logic [CHAN_IN_W-1:0]     channel;
    logic [ACTION_W-1:0]      action;
  } cmd_t;

  // Last member sits in the lowest bits: status first, exit value on top.
  typedef struct packed {
    logic signed [EXIT_W-1:0] child_exit_value;
    logic [RPID_W-1:0]        result_pid;
    logic [SLOT_OUT_W-1:0]    running_slot;
    logic                     running_valid;
    status_e                  status;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/process_table_round_robin_scheduler.sv -----
// Top level of the process-table round-robin scheduler: stream ports,
// output register, and the prrs_seq sequencer over the prrs_table memory.
`timescale 1ns / 1ps
`default_nettype none

// Process-table scheduler. Each input transfer carries one command (tuser:
// action 0 yield, 1 sleep, 2 wakeup, 3 exit, 4 wait, 5 fork, 6 create root;
// tdata: channel and exit value) and gives exactly one result transfer with
// the status, the slot running afterwards, the new or reaped pid, and the
// reaped child's exit value. The slot table lives in a single-port-read,
// single-port-write memory; the sequencer walks it one entry per cycle to
// wake sleepers, pick the next Ready slot round-robin after the current one,
// find a child to reap, drop stale parent links, or find the lowest Unused
// slot. Commands refused up front and unknown actions touch no table
// entry; a blocking wait takes the longest path: a child sweep, then a
// full pick sweep. One command is in work at a time; the next is taken
// once the result sits in the output register, even while that result
// still waits for the sink. After reset the table reads as all Unused
// with no wait.
module process_table_round_robin_scheduler #(
  parameter int unsigned SLOTS        = 16,
  parameter int unsigned CHANNEL_BITS = 16,
  parameter int unsigned PID_BITS     = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata, low bit up: channel[15:0], exit_value_in[31:0]
  input  wire logic [prrs_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tuser: action[2:0]
  input  wire logic [prrs_pkg::ACTION_W-1:0]      s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata, low bit up: status[2:0], running_valid, running_slot[3:0],
  // result_pid[15:0], child_exit_value[31:0]
  output logic [prrs_pkg::OUT_DATA_W-1:0]         m_axis_tdata_o
);

  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned PAR_W   = $clog2(SLOTS + 1);
  localparam int unsigned CHAN_W  = (CHANNEL_BITS < prrs_pkg::CHAN_IN_W) ?
                                    CHANNEL_BITS : prrs_pkg::CHAN_IN_W;
  localparam int unsigned VAL_W   = (CHAN_W > SLOT_W) ? CHAN_W : SLOT_W;
  localparam int unsigned TAG_W   = VAL_W + 1;
  // Table entry: state, sleep tag, parent link, pid, exit value.
  localparam int unsigned ENTRY_W = prrs_pkg::STATE_W + TAG_W + PAR_W + PID_BITS +
                                    prrs_pkg::EXIT_W;

  prrs_pkg::cmd_t     cmd;
  prrs_pkg::rsp_t     rsp;
  logic               rsp_valid;
  logic               out_ready;
  logic               out_valid_q;
  prrs_pkg::rsp_t     out_q;

  logic               mem_re;
  logic [SLOT_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // Unpack the command transfer.
  always_comb begin
    cmd.action     = s_axis_tuser_i;
    cmd.channel    = s_axis_tdata_i[prrs_pkg::CHAN_IN_W-1:0];
    cmd.exit_value = s_axis_tdata_i[prrs_pkg::IN_DATA_W-1:prrs_pkg::CHAN_IN_W];
  end

  prrs_seq #(
    .SLOTS        (SLOTS),
    .CHANNEL_BITS (CHANNEL_BITS),
    .PID_BITS     (PID_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid_i),
    .cmd_ready_o (s_axis_tready_o),
    .cmd_i       (cmd),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (out_ready),
    .rsp_o       (rsp),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  prrs_table #(
    .SLOTS (SLOTS),
    .WIDTH (ENTRY_W)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // Output register: load a finished result when empty or being drained.
  assign out_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/prrs_table.sv -----
// Slot table storage: one write port, one registered read port.
// Per-entry valid bits make never-written entries read as all zero.
`timescale 1ns / 1ps
`default_nettype none

module prrs_table #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned ADDR_W = $clog2(SLOTS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i
);

  logic [WIDTH-1:0] mem_q [SLOTS];
  logic [WIDTH-1:0] rdata_q;
  logic [SLOTS-1:0] valid_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= valid_q[raddr_i];
      end
    end
  end

  // An entry never written holds the reset contents: all fields zero.
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ----- rtl/prrs_seq.sv -----
// Command sequencer: decodes one command and runs read-modify-write sweeps
// over the slot table (prrs_table). Uses prrs_pkg types and codes.
`timescale 1ns / 1ps
`default_nettype none

module prrs_seq #(
  parameter int unsigned SLOTS        = 16,
  parameter int unsigned CHANNEL_BITS = 16,
  parameter int unsigned PID_BITS     = 16,
  localparam int unsigned SLOT_W  = $clog2(SLOTS),
  localparam int unsigned CNT_W   = SLOT_W + 1,
  localparam int unsigned PAR_W   = $clog2(SLOTS + 1),
  localparam int unsigned CHAN_W  = (CHANNEL_BITS < prrs_pkg::CHAN_IN_W) ?
                                    CHANNEL_BITS : prrs_pkg::CHAN_IN_W,
  localparam int unsigned VAL_W   = (CHAN_W > SLOT_W) ? CHAN_W : SLOT_W,
  localparam int unsigned TAG_W   = VAL_W + 1,
  localparam int unsigned ENTRY_W = prrs_pkg::STATE_W + TAG_W + PAR_W + PID_BITS +
                                    prrs_pkg::EXIT_W
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire prrs_pkg::cmd_t    cmd_i,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output prrs_pkg::rsp_t         rsp_o,
  output logic                   mem_re_o,
  output logic [SLOT_W-1:0]      mem_raddr_o,
  input  wire logic [ENTRY_W-1:0] mem_rdata_i,
  output logic                   mem_we_o,
  output logic [SLOT_W-1:0]      mem_waddr_o,
  output logic [ENTRY_W-1:0]     mem_wdata_o
);

  typedef struct packed {
    prrs_pkg::slot_state_e          state;
    logic [TAG_W-1:0]               tag;    // MSB marks a wait sleeper
    logic [PAR_W-1:0]               parent; // 0 none, else parent slot + 1
    logic [PID_BITS-1:0]            pid;
    logic [prrs_pkg::EXIT_W-1:0]    exitv;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CUR_RD,
    S_CUR_WB,
    S_WAKE,
    S_PICK,
    S_CHILD,
    S_UNLINK,
    S_BLOCK,
    S_ALLOC,
    S_DONE
  } fsm_e;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] a);
    return (a == SLOT_W'(SLOTS - 1)) ? '0 : a + SLOT_W'(1);
  endfunction

  fsm_e                        state_q, state_d;
  prrs_pkg::cmd_t              cmd_q, cmd_d;
  logic                        cur_valid_q, cur_valid_d;
  logic [SLOT_W-1:0]           cur_slot_q, cur_slot_d;
  logic [PID_BITS-1:0]         next_pid_q, next_pid_d;
  logic [CNT_W-1:0]            rd_cnt_q, rd_cnt_d;
  logic [SLOT_W-1:0]           rd_addr_q, rd_addr_d;
  logic                        rvalid_q, rvalid_d;
  logic [SLOT_W-1:0]           raddr_q, raddr_d;
  ent_t                        ent_cur_q, ent_cur_d;
  logic [TAG_W-1:0]            tag_q, tag_d;
  logic                        has_child_q, has_child_d;
  logic [SLOT_W-1:0]           child_q, child_d;
  logic [PID_BITS-1:0]         rpid_q, rpid_d;
  logic [prrs_pkg::EXIT_W-1:0] rexit_q, rexit_d;
  prrs_pkg::status_e           status_q, status_d;

  ent_t              rd_ent;
  ent_t              wr_ent;
  logic              last;
  logic              issue;
  logic              start_sweep;
  logic              is_child;
  logic [SLOT_W-1:0] pick_start;
  logic [PAR_W-1:0]  cur_link;
  logic [PAR_W-1:0]  child_link;

  assign rd_ent      = ent_t'(mem_rdata_i);
  assign mem_wdata_o = wr_ent;
  assign last        = (rd_cnt_q == CNT_W'(SLOTS));
  assign pick_start  = cur_valid_q ? slot_inc(cur_slot_q) : '0;
  assign cur_link    = PAR_W'(cur_slot_q) + PAR_W'(1);
  assign child_link  = PAR_W'(child_q) + PAR_W'(1);
  assign is_child    = rvalid_q && (rd_ent.state != prrs_pkg::ST_UNUSED) &&
                       (rd_ent.parent == cur_link);

  assign cmd_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_DONE);

  always_comb begin
    rsp_o.status           = status_q;
    rsp_o.running_valid    = cur_valid_q;
    rsp_o.running_slot     = prrs_pkg::SLOT_OUT_W'(cur_slot_q);
    rsp_o.result_pid       = prrs_pkg::RPID_W'(rpid_q);
    rsp_o.child_exit_value = rexit_q;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cur_valid_d = cur_valid_q;
    cur_slot_d  = cur_slot_q;
    next_pid_d  = next_pid_q;
    rd_cnt_d    = rd_cnt_q;
    rd_addr_d   = rd_addr_q;
    rvalid_d    = 1'b0;
    raddr_d     = raddr_q;
    ent_cur_d   = ent_cur_q;
    tag_d       = tag_q;
    has_child_d = has_child_q;
    child_d     = child_q;
    rpid_d      = rpid_q;
    rexit_d     = rexit_q;
    status_d    = status_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_addr_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = raddr_q;
    wr_ent      = rd_ent;
    issue       = 1'b0;
    start_sweep = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d    = cmd_i;
          status_d = prrs_pkg::STS_OK;
          rpid_d   = '0;
          rexit_d  = '0;
          state_d  = S_DECODE;
        end
      end

      S_DECODE: begin
        case (cmd_q.action)
          prrs_pkg::ACT_YIELD: begin
            if (cur_valid_q) begin
              state_d = S_CUR_RD;
            end else begin
              state_d     = S_PICK;
              start_sweep = 1'b1;
            end
          end
          prrs_pkg::ACT_SLEEP, prrs_pkg::ACT_EXIT, prrs_pkg::ACT_WAIT: begin
            if (cur_valid_q) begin
              state_d = S_CUR_RD;
            end else begin
              status_d = prrs_pkg::STS_NO_CUR;
              state_d  = S_DONE;
            end
          end
          prrs_pkg::ACT_WAKEUP: begin
            tag_d       = {1'b0, VAL_W'(cmd_q.channel[CHAN_W-1:0])};
            state_d     = S_WAKE;
            start_sweep = 1'b1;
          end
          prrs_pkg::ACT_FORK: begin
            if (cur_valid_q) begin
              state_d     = S_ALLOC;
              start_sweep = 1'b1;
            end else begin
              status_d = prrs_pkg::STS_NO_CUR;
              state_d  = S_DONE;
            end
          end
          prrs_pkg::ACT_CREATE: begin
            state_d     = S_ALLOC;
            start_sweep = 1'b1;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_CUR_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = cur_slot_q;
        state_d     = S_CUR_WB;
      end

      S_CUR_WB: begin
        ent_cur_d   = rd_ent;
        mem_waddr_o = cur_slot_q;
        case (cmd_q.action)
          prrs_pkg::ACT_YIELD: begin
            if (rd_ent.state == prrs_pkg::ST_RUNNING) begin
              mem_we_o     = 1'b1;
              wr_ent.state = prrs_pkg::ST_READY;
            end
            state_d     = S_PICK;
            start_sweep = 1'b1;
          end
          prrs_pkg::ACT_SLEEP: begin
            mem_we_o     = 1'b1;
            wr_ent.tag   = {1'b0, VAL_W'(cmd_q.channel[CHAN_W-1:0])};
            wr_ent.state = prrs_pkg::ST_SLEEPING;
            state_d      = S_PICK;
            start_sweep  = 1'b1;
          end
          prrs_pkg::ACT_EXIT: begin
            mem_we_o     = 1'b1;
            wr_ent.exitv = cmd_q.exit_value;
            wr_ent.state = prrs_pkg::ST_ZOMBIE;
            wr_ent.tag   = '0;
            start_sweep  = 1'b1;
            // A parent blocked in wait sleeps on its own slot with the wait mark.
            if (rd_ent.parent != '0) begin
              tag_d   = {1'b1, VAL_W'(SLOT_W'(rd_ent.parent - PAR_W'(1)))};
              state_d = S_WAKE;
            end else begin
              state_d = S_PICK;
            end
          end
          prrs_pkg::ACT_WAIT: begin
            has_child_d = 1'b0;
            state_d     = S_CHILD;
            start_sweep = 1'b1;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_WAKE: begin
        issue = !last;
        if (rvalid_q && (rd_ent.state == prrs_pkg::ST_SLEEPING) && (rd_ent.tag == tag_q)) begin
          mem_we_o     = 1'b1;
          wr_ent.state = prrs_pkg::ST_READY;
          wr_ent.tag   = '0;
        end
        if (last) begin
          if (cmd_q.action == prrs_pkg::ACT_EXIT) begin
            state_d     = S_PICK;
            start_sweep = 1'b1;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_PICK: begin
        if (rvalid_q && (rd_ent.state == prrs_pkg::ST_READY)) begin
          mem_we_o     = 1'b1;
          wr_ent.state = prrs_pkg::ST_RUNNING;
          cur_valid_d  = 1'b1;
          cur_slot_d   = raddr_q;
          state_d      = S_DONE;
        end else if (last) begin
          cur_valid_d = 1'b0;
          cur_slot_d  = '0;
          state_d     = S_DONE;
        end else begin
          issue = 1'b1;
        end
      end

      S_CHILD: begin
        if (is_child) begin
          has_child_d = 1'b1;
        end
        if (is_child && (rd_ent.state == prrs_pkg::ST_ZOMBIE)) begin
          // Reap: free the slot, then drop links that point at it.
          mem_we_o    = 1'b1;
          wr_ent      = ent_t'('0);
          rpid_d      = rd_ent.pid;
          rexit_d     = rd_ent.exitv;
          child_d     = raddr_q;
          state_d     = S_UNLINK;
          start_sweep = 1'b1;
        end else if (last) begin
          if (!(has_child_q || is_child)) begin
            status_d = prrs_pkg::STS_NO_CHILD;
            state_d  = S_DONE;
          end else if (ent_cur_q.state == prrs_pkg::ST_RUNNING) begin
            state_d = S_BLOCK;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          issue = 1'b1;
        end
      end

      S_UNLINK: begin
        issue = !last;
        if (rvalid_q && (rd_ent.parent == child_link)) begin
          mem_we_o      = 1'b1;
          wr_ent.parent = '0;
        end
        if (last) begin
          state_d = S_DONE;
        end
      end

      S_BLOCK: begin
        mem_we_o     = 1'b1;
        mem_waddr_o  = cur_slot_q;
        wr_ent       = ent_cur_q;
        wr_ent.tag   = {1'b1, VAL_W'(cur_slot_q)};
        wr_ent.state = prrs_pkg::ST_SLEEPING;
        status_d     = prrs_pkg::STS_BLOCKED;
        state_d      = S_PICK;
        start_sweep  = 1'b1;
      end

      S_ALLOC: begin
        if (rvalid_q && (rd_ent.state == prrs_pkg::ST_UNUSED)) begin
          mem_we_o      = 1'b1;
          wr_ent        = ent_t'('0);
          wr_ent.state  = prrs_pkg::ST_READY;
          wr_ent.parent = (cmd_q.action == prrs_pkg::ACT_FORK) ? cur_link : '0;
          wr_ent.pid    = next_pid_q;
          rpid_d        = next_pid_q;
          // Pids skip zero on wrap.
          next_pid_d    = (&next_pid_q) ? PID_BITS'(1) : next_pid_q + PID_BITS'(1);
          state_d       = S_DONE;
        end else if (last) begin
          status_d = prrs_pkg::STS_FULL;
          state_d  = S_DONE;
        end else begin
          issue = 1'b1;
        end
      end

      S_DONE: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Sweep read issue: one entry per cycle, data returns in the next cycle.
    if (issue) begin
      mem_re_o    = 1'b1;
      mem_raddr_o = rd_addr_q;
      raddr_d     = rd_addr_q;
      rd_addr_d   = slot_inc(rd_addr_q);
      rd_cnt_d    = rd_cnt_q + CNT_W'(1);
      rvalid_d    = 1'b1;
    end

    // Round-robin pick starts after the current slot (at zero if none runs), all other sweeps at zero.
    if (start_sweep) begin
      rd_cnt_d  = '0;
      rd_addr_d = (state_d == S_PICK) ? pick_start : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      cur_valid_q <= 1'b0;
      cur_slot_q  <= '0;
      next_pid_q  <= PID_BITS'(1);
      rd_cnt_q    <= '0;
      rd_addr_q   <= '0;
      rvalid_q    <= 1'b0;
      raddr_q     <= '0;
      ent_cur_q   <= ent_t'('0);
      tag_q       <= '0;
      has_child_q <= 1'b0;
      child_q     <= '0;
      rpid_q      <= '0;
      rexit_q     <= '0;
      status_q    <= prrs_pkg::STS_OK;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      cur_valid_q <= cur_valid_d;
      cur_slot_q  <= cur_slot_d;
      next_pid_q  <= next_pid_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_addr_q   <= rd_addr_d;
      rvalid_q    <= rvalid_d;
      raddr_q     <= raddr_d;
      ent_cur_q   <= ent_cur_d;
      tag_q       <= tag_d;
      has_child_q <= has_child_d;
      child_q     <= child_d;
      rpid_q      <= rpid_d;
      rexit_q     <= rexit_d;
      status_q    <= status_d;
    end
  end

`ifndef SYNTHESIS
  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("table read and write hit the same entry in one cycle");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> !rvalid_q)
    else $error("read data still in flight while idle");

  a_pid_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_pid_q != '0)
    else $error("next pid reached zero");

  a_idle_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_valid_q |-> (cur_slot_q == '0))
    else $error("current slot nonzero with no process running");
`endif

endmodule

`default_nettype wire
